[hw/rtl/lcba_pkg.sv]
// Shared constants and types for the LRU cache block allocator.
// Used by lcba_lru_seq and lru_cache_block_allocator_core; no dependencies.
package lcba_pkg;

    // Fixed port widths
    localparam int CFG_W = 11;
    localparam int ID_W  = 10;
    localparam int TAG_W = 48;

    // Parameter defaults
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int TAG_BITS_DEF   = 48;

    // Block count after reset
    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    // One result beat
    typedef struct packed {
        logic [ID_W-1:0]  write_block;
        logic             evicted;
        logic [TAG_W-1:0] evicted_tag;
        logic             refused;
    } t_result;

endpackage

[hw/rtl/lcba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lcba_lru_seq.sv]
// Request sequencer: classifies each request and walks the LRU list update
// through the link and tag memories. Depends on lcba_pkg and lcba_ram.
module lcba_lru_seq #(
    parameter int MAX_BLOCKS = lcba_pkg::MAX_BLOCKS_DEF,
    parameter int TAG_BITS   = lcba_pkg::TAG_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lcba_pkg::CFG_W-1:0] i_block_count,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_is_hit,
    input  logic [lcba_pkg::ID_W-1:0]  i_hit_block,
    input  logic [lcba_pkg::TAG_W-1:0] i_data_tag,
    input  logic                       i_out_free,
    output logic                       o_push,
    output lcba_pkg::t_result          o_result
);

    localparam int IDW  = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_LINK1 = 3'd2;
    localparam logic [2:0] ST_LINK2 = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Request classes
    localparam logic [1:0] OP_REFUSE = 2'd0;
    localparam logic [1:0] OP_HIT    = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;
    localparam logic [1:0] OP_EVICT  = 2'd3;

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [CNTW-1:0]     r_next_fresh, n_next_fresh;
    logic [IDW-1:0]      r_most, n_most;
    logic [IDW-1:0]      r_least, n_least;
    logic [IDW-1:0]      r_blk, n_blk;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    lcba_pkg::t_result   r_res, n_res;

    logic                accept;
    logic [31:0]         hit32, fresh32, limit32, blk32;
    logic [63:0]         tag64, evtag64;
    logic                hit_ok, fill_ok, fresh_zero;
    logic [IDW-1:0]      hit_idx, fresh_idx, a_blk;
    logic                blk_is_most, blk_is_least;

    logic                older_we, newer_we, tag_we;
    logic [IDW-1:0]      older_waddr, newer_waddr;
    logic [IDW-1:0]      older_wdata, newer_wdata;
    logic [IDW-1:0]      older_rdata, newer_rdata;
    logic [TAG_BITS-1:0] tag_rdata;

    // Link and tag memories
    lcba_ram #(.WIDTH(IDW), .DEPTH(MAX_BLOCKS)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (older_we),
        .i_waddr (older_waddr),
        .i_wdata (older_wdata),
        .i_raddr (a_blk),
        .o_rdata (older_rdata)
    );

    lcba_ram #(.WIDTH(IDW), .DEPTH(MAX_BLOCKS)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (newer_we),
        .i_waddr (newer_waddr),
        .i_wdata (newer_wdata),
        .i_raddr (a_blk),
        .o_rdata (newer_rdata)
    );

    lcba_ram #(.WIDTH(TAG_BITS), .DEPTH(MAX_BLOCKS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_blk),
        .i_wdata (r_tag),
        .i_raddr (a_blk),
        .o_rdata (tag_rdata)
    );

    // Classify the incoming request against the allocation state
    always_comb begin
        hit32      = 32'(i_hit_block);
        fresh32    = 32'(r_next_fresh);
        limit32    = (32'(i_block_count) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS)
                                                            : 32'(i_block_count);
        hit_ok     = hit32 < fresh32;
        fill_ok    = fresh32 < limit32;
        fresh_zero = (r_next_fresh == '0);
        hit_idx    = hit32[IDW-1:0];
        fresh_idx  = r_next_fresh[IDW-1:0];
        tag64      = 64'(i_data_tag);
        accept     = i_in_valid && (r_state == ST_IDLE);
        if (i_is_hit) begin
            a_blk = hit_idx;
        end else if (fill_ok) begin
            a_blk = fresh_idx;
        end else begin
            a_blk = r_least;
        end
    end

    assign blk_is_most  = (r_blk == r_most);
    assign blk_is_least = (r_blk == r_least);
    assign blk32        = 32'(r_blk);
    assign evtag64      = 64'(tag_rdata);

    // Memory write steering per sequencer step
    always_comb begin
        older_we    = 1'b0;
        older_waddr = r_blk;
        older_wdata = r_most;
        newer_we    = 1'b0;
        newer_waddr = r_most;
        newer_wdata = r_blk;
        tag_we      = 1'b0;
        case (r_state)
            ST_FILL: begin
                // append fresh block behind the current most-recent one
                tag_we   = 1'b1;
                older_we = !fresh_zero;
                newer_we = !fresh_zero;
            end
            ST_LINK1: begin
                // unlink the block from its neighbors
                tag_we      = (r_op == OP_EVICT);
                older_we    = !blk_is_most;
                older_waddr = newer_rdata;
                older_wdata = older_rdata;
                newer_we    = !blk_is_most && !blk_is_least;
                newer_waddr = older_rdata;
                newer_wdata = newer_rdata;
            end
            ST_LINK2: begin
                // relink it at the most-recent end
                older_we = 1'b1;
                newer_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_next_fresh = r_next_fresh;
        n_most       = r_most;
        n_least      = r_least;
        n_blk        = r_blk;
        n_tag        = r_tag;
        n_res        = r_res;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_blk = a_blk;
                    n_tag = tag64[TAG_BITS-1:0];
                    n_res = '0;
                    if (i_is_hit && hit_ok) begin
                        n_op    = OP_HIT;
                        n_state = ST_LINK1;
                    end else if (i_is_hit || (!fill_ok && fresh_zero)) begin
                        n_op          = OP_REFUSE;
                        n_res.refused = 1'b1;
                        n_state       = ST_DONE;
                    end else if (fill_ok) begin
                        n_op    = OP_FILL;
                        n_state = ST_FILL;
                    end else begin
                        n_op          = OP_EVICT;
                        n_res.evicted = 1'b1;
                        n_state       = ST_LINK1;
                    end
                end
            end
            ST_FILL: begin
                if (fresh_zero) begin
                    n_least = r_blk;
                end
                n_most            = r_blk;
                n_next_fresh      = r_next_fresh + CNTW'(1);
                n_res.write_block = blk32[lcba_pkg::ID_W-1:0];
                n_state           = ST_DONE;
            end
            ST_LINK1: begin
                n_res.write_block = blk32[lcba_pkg::ID_W-1:0];
                if (r_op == OP_EVICT) begin
                    n_res.evicted_tag = evtag64[lcba_pkg::TAG_W-1:0];
                end
                if (blk_is_most) begin
                    n_state = ST_DONE;
                end else begin
                    if (blk_is_least) begin
                        n_least = newer_rdata;
                    end
                    n_state = ST_LINK2;
                end
            end
            ST_LINK2: begin
                n_most  = r_blk;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output stage can take the beat
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_next_fresh <= '0;
            r_most       <= '0;
            r_least      <= '0;
        end else begin
            r_state      <= n_state;
            r_next_fresh <= n_next_fresh;
            r_most       <= n_most;
            r_least      <= n_least;
        end
    end

    // Request payload
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_blk <= n_blk;
        r_tag <= n_tag;
        r_res <= n_res;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_push     = (r_state == ST_DONE) && i_out_free;
    assign o_result   = r_res;

endmodule

[hw/rtl/lru_cache_block_allocator_core.sv]
// Top level of the LRU cache block allocator: config register, sequencer and
// output register. Depends on lcba_pkg and lcba_lru_seq.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------------------
//   request  | in        | i_in_valid / o_in_ready      | i_is_hit, i_hit_block, i_data_tag
//   result   | out       | o_out_valid / i_out_ready    | o_write_block, o_evicted,
//            |           |                              | o_evicted_tag, o_refused
//   config   | in        | i_cfg_wr_en (no wait)        | i_cfg_wr_data (block_count)
//
// A refused request goes to done, a fresh fill via a fill step, a hit/evict
// on the most-recent block via an unlink step, and one that relinks the list
// via an unlink and a relink step, as the link memories have a registered
// read and one write port each. One request is in flight at a time. A full
// output register stalls the sequencer in its final step. Reset (synchronous,
// active low) empties the allocation and sets block_count to 1024.
module lru_cache_block_allocator_core #(
    parameter int MAX_BLOCKS = lcba_pkg::MAX_BLOCKS_DEF,
    parameter int TAG_BITS   = lcba_pkg::TAG_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [lcba_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_is_hit,
    input  logic [lcba_pkg::ID_W-1:0]  i_hit_block,
    input  logic [lcba_pkg::TAG_W-1:0] i_data_tag,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lcba_pkg::ID_W-1:0]  o_write_block,
    output logic                       o_evicted,
    output logic [lcba_pkg::TAG_W-1:0] o_evicted_tag,
    output logic                       o_refused
);

    logic [lcba_pkg::CFG_W-1:0] r_block_count;
    logic                       r_out_valid;
    lcba_pkg::t_result          r_out;
    logic                       out_free;
    logic                       push;
    lcba_pkg::t_result          result;

    // Block count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= lcba_pkg::BLOCK_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_block_count <= i_cfg_wr_data;
        end
    end

    lcba_lru_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .TAG_BITS   (TAG_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_block_count (r_block_count),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_is_hit      (i_is_hit),
        .i_hit_block   (i_hit_block),
        .i_data_tag    (i_data_tag),
        .i_out_free    (out_free),
        .o_push        (push),
        .o_result      (result)
    );

    // Output register: load a finished beat, drop it once taken
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_block = r_out.write_block;
    assign o_evicted     = r_out.evicted;
    assign o_evicted_tag = r_out.evicted_tag;
    assign o_refused     = r_out.refused;

endmodule
